// ----- src/bba_pkg.sv -----
// bba_pkg: shared types, field widths and codes for the bitmap block allocator.
// No dependencies.
package bba_pkg;

	localparam int MODE_W    = 2;
	localparam int BLK_W     = 12;
	localparam int STAT_W    = 2;
	localparam int CFG_W     = 13;
	localparam int WORD_BITS = 32;
	localparam int BIT_IDX_W = 5;

	typedef logic [MODE_W-1:0]    mode_t;
	typedef logic [BLK_W-1:0]     blk_t;
	typedef logic [STAT_W-1:0]    stat_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [BIT_IDX_W-1:0] bit_idx_t;

	localparam mode_t MODE_QUERY = 2'd0;
	localparam mode_t MODE_ALLOC = 2'd1;
	localparam mode_t MODE_FREE  = 2'd2;

	localparam stat_t STAT_OK       = 2'd0;
	localparam stat_t STAT_NO_SPACE = 2'd1;
	localparam stat_t STAT_BAD_BLK  = 2'd2;

	// lowest set bit of a map word, binary search
	function automatic bit_idx_t first_set(input word_t w);
		word_t    v;
		bit_idx_t idx;
		v   = w;
		idx = '0;
		if (v[15:0] == 16'd0) begin
			idx[4] = 1'b1;
			v      = v >> 16;
		end
		if (v[7:0] == 8'd0) begin
			idx[3] = 1'b1;
			v      = v >> 8;
		end
		if (v[3:0] == 4'd0) begin
			idx[2] = 1'b1;
			v      = v >> 4;
		end
		if (v[1:0] == 2'd0) begin
			idx[1] = 1'b1;
			v      = v >> 2;
		end
		if (v[0] == 1'b0) begin
			idx[0] = 1'b1;
		end
		return idx;
	endfunction

endpackage

// ----- src/bitmap_block_allocator_top.sv -----
// bitmap_block_allocator_top: next-fit block allocator over a free bitmap kept in
// one synchronous RAM of 32-bit words. Depends on bba_pkg.
//
// Usage:
//  - Request channel (in_valid/in_ready): mode and block_number. Query, allocate
//    or free one block per transfer. One request is in work at a time.
//  - Result channel (out_valid/out_ready): result_block, block_free, status, one
//    transfer per request, in order. A registered output slot lets the next
//    request be taken while a result waits; a stalled receiver holds the slot and
//    the block stops at the end of the following request.
//  - Config channel (cfg_valid/cfg_ready): total_blocks, always ready; write only
//    while the block is idle.
//  - Flow: query and free read the addressed map word before the result; a
//    rejected free, the unused mode and an allocate with a zero count go straight
//    to the result. Allocate scans W map words (1 to ceil(count/32) + 1, one RAM
//    read per cycle), after a bit-serial modulo that runs only when the last
//    allocated block lies at or past the current count.
//  - Reset: the bitmap RAM is cleared to all in use by a pass over its words, one
//    word a cycle; in_ready stays low until it ends.
module bitmap_block_allocator_top #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bba_pkg::mode_t         mode,
	input  bba_pkg::blk_t          block_number,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bba_pkg::blk_t          result_block,
	output logic                   block_free,
	output bba_pkg::stat_t         status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [bba_pkg::CFG_W-1:0] total_blocks
);

	localparam int WB    = bba_pkg::WORD_BITS;
	localparam int BI_W  = bba_pkg::BIT_IDX_W;
	localparam int IW    = $clog2(MAX_BLOCKS);
	localparam int CNT_W = ($clog2(MAX_BLOCKS + 1) > bba_pkg::CFG_W) ?
		$clog2(MAX_BLOCKS + 1) : bba_pkg::CFG_W;
	localparam int WORDS = (MAX_BLOCKS + WB - 1) / WB;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int MC_W  = $clog2(IW + 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WORD  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_SINIT = 3'd4;
	localparam logic [2:0] S_SCAN  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	localparam bba_pkg::word_t ALL_ONES = '1;

	logic [2:0]                state_q;
	logic [WAW-1:0]            clr_q;
	logic [bba_pkg::CFG_W-1:0] total_q;
	logic [IW-1:0]             last_q;

	bba_pkg::mode_t            req_mode_q;
	bba_pkg::blk_t             req_blk_q;
	bba_pkg::blk_t             res_blk_q;
	logic                      res_free_q;
	bba_pkg::stat_t            res_stat_q;

	logic [CNT_W-1:0]          rem_q;
	logic [IW-1:0]             dv_q;
	logic [MC_W-1:0]           mc_q;
	logic [IW-1:0]             s_q;

	logic [WAW-1:0]            iw_q;
	logic [WAW:0]              ic_q;
	logic                      vld_s1;
	logic                      first_s1;
	logic                      last_s1;
	logic [WAW-1:0]            iw_s1;

	logic                      out_valid_q;
	bba_pkg::blk_t             out_blk_q;
	logic                      out_free_q;
	bba_pkg::stat_t            out_stat_q;

	bba_pkg::word_t            mem [WORDS];
	bba_pkg::word_t            rd_s1;
	logic [WAW-1:0]            ra;
	logic                      we;
	logic [WAW-1:0]            wa;
	bba_pkg::word_t            wd;

	logic [CNT_W-1:0]          cnt;
	logic [CNT_W-1:0]          cnt_m1;
	logic [WAW-1:0]            last_word;
	bba_pkg::bit_idx_t         lb;
	logic [WAW:0]              nw;
	logic [CNT_W-1:0]          blk_in_ext;
	logic [CNT_W-1:0]          req_ext;
	logic                      req_ok;
	bba_pkg::bit_idx_t         req_bit;
	logic [CNT_W:0]            mod_t;
	logic [CNT_W-1:0]          rem_nxt;
	bba_pkg::bit_idx_t         sbit;
	bba_pkg::word_t            ge_mask;
	bba_pkg::word_t            lim_mask;
	bba_pkg::word_t            masked;
	logic                      hit;
	bba_pkg::bit_idx_t         hit_bit;
	logic [CNT_W-1:0]          hit_idx;
	logic                      issue;
	logic                      accept;
	logic                      load_out;

	// effective count and scan geometry
	always_comb begin
		cnt        = (CNT_W'(total_q) > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) :
			CNT_W'(total_q);
		cnt_m1     = cnt - 1'b1;
		last_word  = WAW'(cnt_m1 >> BI_W);
		lb         = cnt_m1[BI_W-1:0];
		nw         = {1'b0, last_word} + 1'b1;
		blk_in_ext = CNT_W'(block_number);
		req_ext    = CNT_W'(req_blk_q);
		req_ok     = req_ext < cnt;
		req_bit    = req_blk_q[BI_W-1:0];
		mod_t      = {rem_q, dv_q[IW-1]};
		rem_nxt    = (mod_t >= {1'b0, cnt}) ? CNT_W'(mod_t - {1'b0, cnt}) : CNT_W'(mod_t);
		sbit       = s_q[BI_W-1:0];
		ge_mask    = ALL_ONES << sbit;
		lim_mask   = (iw_s1 == last_word) ? (ALL_ONES >> (BI_W'(WB - 1) - lb)) : ALL_ONES;
		masked     = rd_s1 & lim_mask & (first_s1 ? ge_mask : ALL_ONES) &
			(last_s1 ? ~ge_mask : ALL_ONES);
		hit        = vld_s1 && (masked != '0);
		hit_bit    = bba_pkg::first_set(masked);
		hit_idx    = (CNT_W'(iw_s1) << BI_W) | CNT_W'(hit_bit);
		issue      = ic_q <= nw;
		accept     = in_valid && in_ready;
		load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	// RAM port control
	always_comb begin
		ra = iw_q;
		we = 1'b0;
		wa = iw_s1;
		wd = rd_s1 & ~(bba_pkg::word_t'(1) << hit_bit);
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
			end
			S_IDLE: begin
				ra = WAW'(blk_in_ext >> BI_W);
			end
			S_WORD: begin
				wa = WAW'(req_ext >> BI_W);
				wd = rd_s1 | (bba_pkg::word_t'(1) << req_bit);
				we = (req_mode_q == bba_pkg::MODE_FREE);
			end
			S_SCAN: begin
				we = hit;
			end
			default: begin
				ra = iw_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			last_q      <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				total_q <= total_blocks;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WAW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (mode)
							bba_pkg::MODE_QUERY: begin
								state_q <= S_WORD;
							end
							bba_pkg::MODE_FREE: begin
								if (block_number == '0 || blk_in_ext >= cnt) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_WORD;
								end
							end
							bba_pkg::MODE_ALLOC: begin
								if (cnt == '0) begin
									state_q <= S_DONE;
								end else if (CNT_W'(last_q) < cnt) begin
									state_q <= S_SINIT;
								end else begin
									state_q <= S_MOD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WORD: begin
					state_q <= S_DONE;
				end
				S_MOD: begin
					if (mc_q == MC_W'(1)) begin
						state_q <= S_SINIT;
					end
				end
				S_SINIT: begin
					vld_s1  <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						last_q  <= IW'(hit_idx);
						vld_s1  <= 1'b0;
						state_q <= S_DONE;
					end else if (vld_s1 && last_s1) begin
						vld_s1  <= 1'b0;
						state_q <= S_DONE;
					end else begin
						vld_s1 <= issue;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request, search and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_mode_q <= mode;
					req_blk_q  <= block_number;
					res_blk_q  <= block_number;
					res_free_q <= 1'b0;
					res_stat_q <= bba_pkg::STAT_OK;
					s_q        <= last_q;
					rem_q      <= '0;
					dv_q       <= last_q;
					mc_q       <= MC_W'(IW);
					if (mode == bba_pkg::MODE_FREE &&
						(block_number == '0 || blk_in_ext >= cnt)) begin
						res_stat_q <= bba_pkg::STAT_BAD_BLK;
					end
					if (mode == bba_pkg::MODE_ALLOC && cnt == '0) begin
						res_stat_q <= bba_pkg::STAT_NO_SPACE;
					end
				end
			end
			S_WORD: begin
				if (req_mode_q == bba_pkg::MODE_QUERY) begin
					res_free_q <= req_ok && rd_s1[req_bit];
				end
			end
			S_MOD: begin
				rem_q <= rem_nxt;
				dv_q  <= dv_q << 1;
				mc_q  <= mc_q - 1'b1;
				s_q   <= IW'(rem_nxt);
			end
			S_SINIT: begin
				iw_q <= WAW'(CNT_W'(s_q) >> BI_W);
				ic_q <= '0;
			end
			S_SCAN: begin
				if (hit) begin
					res_blk_q  <= bba_pkg::blk_t'(hit_idx);
					res_stat_q <= bba_pkg::STAT_OK;
				end else if (vld_s1 && last_s1) begin
					res_stat_q <= bba_pkg::STAT_NO_SPACE;
				end
				if (issue) begin
					first_s1 <= (ic_q == '0);
					last_s1  <= (ic_q == nw);
					iw_s1    <= iw_q;
					iw_q     <= (iw_q == last_word) ? '0 : iw_q + 1'b1;
					ic_q     <= ic_q + 1'b1;
				end
			end
			S_DONE: begin
				if (load_out) begin
					out_blk_q  <= res_blk_q;
					out_free_q <= res_free_q;
					out_stat_q <= res_stat_q;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign result_block = out_blk_q;
	assign block_free   = out_free_q;
	assign status       = out_stat_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while another is in work");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && hit) |-> (hit_idx < cnt))
		else $error("allocated block outside the managed count");

	a_free_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(block_free && status != bba_pkg::STAT_OK))
		else $error("free flag set on a failed request");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!in_ready && we))
		else $error("bitmap clear pass not exclusive");
`endif

endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for bitmap_block_allocator_top. A directed table
// runs first, then randomized request phases over several block counts and paces.
// Depends on bba_pkg and the allocator RTL; results are checked against a next-fit model or fixed table values.
module testbench;

	localparam int                   MAX_BLK       = 4096;
	localparam int unsigned          CYCLE_LIMIT   = 1_000_000;
	localparam int                   CFG_W         = bba_pkg::CFG_W;
	localparam bba_pkg::mode_t       MODE_QUERY    = bba_pkg::MODE_QUERY;
	localparam bba_pkg::mode_t       MODE_ALLOC    = bba_pkg::MODE_ALLOC;
	localparam bba_pkg::mode_t       MODE_FREE     = bba_pkg::MODE_FREE;
	localparam bba_pkg::mode_t       MODE_NOP      = 2'd3;
	localparam bba_pkg::stat_t       STAT_OK       = bba_pkg::STAT_OK;
	localparam bba_pkg::stat_t       STAT_NO_SPACE = bba_pkg::STAT_NO_SPACE;
	localparam bba_pkg::stat_t       STAT_BAD_BLK  = bba_pkg::STAT_BAD_BLK;

	typedef struct packed {
		bba_pkg::blk_t  result_block;
		logic           block_free;
		bba_pkg::stat_t status;
	} alloc_result_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_FIXED, ROW_PREDICT} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [CFG_W-1:0]  count;
		bba_pkg::mode_t    req_mode;
		bba_pkg::blk_t     req_blk;
		alloc_result_t     fixed;
	} dir_row_t;

	typedef enum int {PACE_FULL, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_ready;
	bba_pkg::mode_t   mode         = MODE_QUERY;
	bba_pkg::blk_t    block_number = '0;
	logic             out_valid;
	logic             out_ready    = 1'b0;
	bba_pkg::blk_t    result_block;
	logic             block_free;
	bba_pkg::stat_t   status;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] total_blocks = '0;

	// allocator model state
	logic [MAX_BLK-1:0] free_bits  = '0;
	bba_pkg::blk_t      last_alloc = '0;
	logic [CFG_W-1:0]   count_reg  = '0;

	alloc_result_t pending[$];
	int unsigned   mismatches  = 0;
	int unsigned   cycle_count = 0;
	int            snd_pct     = 0;
	int            rcv_pct     = 0;

	dir_row_t dir_rows [29] = '{
		'{ROW_FIXED,   13'd0,    MODE_QUERY, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_ALLOC, 12'd5,    '{12'd5,    1'b0, STAT_NO_SPACE}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd1,    '{12'd1,    1'b0, STAT_BAD_BLK}},
		'{ROW_FIXED,   13'd0,    MODE_NOP,   12'd4095, '{12'd4095, 1'b0, STAT_OK}},
		'{ROW_CFG,     13'd64,   MODE_QUERY, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd0,    '{12'd0,    1'b0, STAT_BAD_BLK}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd64,   '{12'd64,   1'b0, STAT_BAD_BLK}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd63,   '{12'd63,   1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd1,    '{12'd1,    1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_QUERY, 12'd63,   '{12'd63,   1'b1, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_QUERY, 12'd4095, '{12'd4095, 1'b0, STAT_OK}},
		'{ROW_PREDICT, 13'd0,    MODE_ALLOC, 12'd7,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_PREDICT, 13'd0,    MODE_ALLOC, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_ALLOC, 12'd4095, '{12'd4095, 1'b0, STAT_NO_SPACE}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd40,   '{12'd40,   1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd2,    '{12'd2,    1'b0, STAT_OK}},
		'{ROW_CFG,     13'd8191, MODE_QUERY, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd4095, '{12'd4095, 1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_QUERY, 12'd4095, '{12'd4095, 1'b1, STAT_OK}},
		'{ROW_PREDICT, 13'd0,    MODE_ALLOC, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_CFG,     13'd33,   MODE_QUERY, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_FREE,  12'd33,   '{12'd33,   1'b0, STAT_BAD_BLK}},
		'{ROW_PREDICT, 13'd0,    MODE_ALLOC, 12'hAAA,  '{12'd0,    1'b0, STAT_OK}},
		'{ROW_FIXED,   13'd0,    MODE_ALLOC, 12'h555,  '{12'h555,  1'b0, STAT_NO_SPACE}},
		'{ROW_FIXED,   13'd0,    MODE_QUERY, 12'd40,   '{12'd40,   1'b0, STAT_OK}},
		'{ROW_CFG,     13'd64,   MODE_QUERY, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_PREDICT, 13'd0,    MODE_QUERY, 12'd40,   '{12'd0,    1'b0, STAT_OK}},
		'{ROW_PREDICT, 13'd0,    MODE_ALLOC, 12'd0,    '{12'd0,    1'b0, STAT_OK}},
		'{ROW_PREDICT, 13'd0,    MODE_ALLOC, 12'd0,    '{12'd0,    1'b0, STAT_OK}}
	};

	bitmap_block_allocator_top #(.MAX_BLOCKS(MAX_BLK)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.block_number (block_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block),
		.block_free   (block_free),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.total_blocks (total_blocks)
	);

	always #1 clk = ~clk;

	function automatic int unsigned managed_blocks();
		return (count_reg > MAX_BLK) ? MAX_BLK : int'(count_reg);
	endfunction

	function automatic logic model_block_free(int unsigned idx);
		return (idx < managed_blocks()) && free_bits[idx];
	endfunction

	function automatic alloc_result_t next_fit_step(bba_pkg::mode_t m, bba_pkg::blk_t b);
		alloc_result_t r;
		int unsigned   n;
		int unsigned   j;
		int unsigned   i;
		n              = managed_blocks();
		r.result_block = b;
		r.block_free   = 1'b0;
		r.status       = STAT_OK;
		case (m)
			MODE_QUERY: r.block_free = model_block_free(b);
			MODE_ALLOC: begin
				r.status = STAT_NO_SPACE;
				if (n != 0) begin
					j = last_alloc % n;
					for (i = 0; i < n; i++) begin
						if (model_block_free(j)) begin
							free_bits[j]   = 1'b0;
							last_alloc     = bba_pkg::blk_t'(j);
							r.result_block = bba_pkg::blk_t'(j);
							r.status       = STAT_OK;
							break;
						end
						j = (j + 1 == n) ? 0 : j + 1;
					end
				end
			end
			MODE_FREE: begin
				if (b == 0 || b >= n)
					r.status = STAT_BAD_BLK;
				else
					free_bits[b] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic log_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// one request transfer; valid stays high into the next request unless a gap is drawn
	task automatic issue_request(bba_pkg::mode_t m, bba_pkg::blk_t b, bit use_fixed,
		alloc_result_t fixed_res);
		alloc_result_t res;
		if ($urandom_range(0, 99) < snd_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < snd_pct);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		block_number <= b;
		do @(posedge clk); while (!in_ready);
		res = next_fit_step(m, b);
		pending.push_back(use_fixed ? fixed_res : res);
	endtask

	task automatic write_block_count(logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid    <= 1'b1;
		total_blocks <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_reg  = v;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] cnt, int items, pace_t pace);
		int unsigned    n;
		int unsigned    hi;
		int unsigned    pick;
		bba_pkg::mode_t m;
		bba_pkg::blk_t  b;
		write_block_count(cnt);
		case (pace)
			PACE_FULL: begin snd_pct = 0;  rcv_pct = 0;  end
			PACE_SEND: begin snd_pct = 57; rcv_pct = 0;  end
			PACE_RECV: begin snd_pct = 0;  rcv_pct = 57; end
			default:   begin snd_pct = 18; rcv_pct = 18; end
		endcase
		n  = managed_blocks();
		hi = (n + 1 > MAX_BLK - 1) ? MAX_BLK - 1 : n + 1;
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				m = MODE_FREE;
			else if (pick < 75)
				m = MODE_ALLOC;
			else if (pick < 95)
				m = MODE_QUERY;
			else
				m = MODE_NOP;
			if ($urandom_range(0, 4) == 0)
				b = bba_pkg::blk_t'($urandom);
			else
				b = bba_pkg::blk_t'($urandom_range(0, hi));
			issue_request(m, b, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				log_mismatch($sformatf("unexpected result block %0d free %0b status %0d",
					result_block, block_free, status));
			end else begin
				want = pending.pop_front();
				if (result_block !== want.result_block)
					log_mismatch($sformatf("result_block exp %0d got %0d",
						want.result_block, result_block));
				if (block_free !== want.block_free)
					log_mismatch($sformatf("block_free exp %0b got %0b",
						want.block_free, block_free));
				if (status !== want.status)
					log_mismatch($sformatf("status exp %0d got %0d", want.status, status));
			end
		end
		out_ready <= ($urandom_range(0, 99) >= rcv_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG)
				write_block_count(dir_rows[k].count);
			else
				issue_request(dir_rows[k].req_mode, dir_rows[k].req_blk,
					dir_rows[k].kind == ROW_FIXED, dir_rows[k].fixed);
		end

		run_phase(13'd40,   200, PACE_FULL);
		run_phase(13'd1,    60,  PACE_SEND);
		run_phase(13'd300,  200, PACE_RECV);
		run_phase(13'd96,   200, PACE_BOTH);
		run_phase(13'd8191, 80,  PACE_FULL);
		run_phase(13'd4096, 60,  PACE_SEND);
		run_phase(13'd0,    30,  PACE_RECV);
		run_phase(13'd17,   200, PACE_BOTH);
		repeat (3)
			run_phase(CFG_W'($urandom_range(2, 512)), 120, pace_t'($urandom_range(0, 3)));

		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
